@@ design/vsbp_pkg.sv @@
// Shared types, register codes and constants for the vertical scroll blit planner.
// No dependencies; every other design file refers to this package by scoped names.
package vsbp_pkg;

    localparam logic [13:0] MAX_VIEWPORT_DIM = 14'd8192;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_VIEW_COLS = 2'd0;
    localparam logic [1:0] REG_VIEW_ROWS = 2'd1;
    localparam logic [1:0] REG_DOC_ROWS  = 2'd2;

    localparam logic [13:0] RST_VIEW_COLS = 14'd640;
    localparam logic [13:0] RST_VIEW_ROWS = 14'd480;
    localparam logic [14:0] RST_DOC_ROWS  = 15'd480;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_FAST = 2'd1,
        MODE_FULL = 2'd2
    } t_mode;

    typedef struct packed {
        logic [13:0] view_cols;
        logic [13:0] view_rows;
        logic [14:0] doc_rows;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] previous_offset;
        logic signed [15:0] requested_offset;
    } t_in;

    typedef struct packed {
        t_mode              blit_mode;
        logic [14:0]        clamped_previous;
        logic [14:0]        clamped_current;
        logic signed [15:0] scroll_delta;
        logic [12:0]        source_row;
        logic [12:0]        dest_row;
        logic [12:0]        moved_rows;
        logic [12:0]        strip_row;
        logic [13:0]        strip_rows;
        logic [25:0]        moved_pixel_count;
        logic [26:0]        exposed_pixel_count;
    } t_out;

endpackage

@@ design/vertical_scroll_blit_planner.sv @@
// Top level of the vertical scroll blit planner: input register, planning logic, result register.
// Depends on vsbp_pkg, vsbp_regs and vsbp_plan.
//
// One scroll request per clock, sustained while the output is not stalled. A beat taken on the
// input channel is held in the input register, planned from there by one pass of clamp, compare
// and two 14x14 multipliers, and lands in the result register once that register is free.
// The result register and input register stall independently, so a new request is taken while
// a finished plan waits; the input stalls only when both registers are full and the output is
// stalled. Configuration registers are read directly by the planning logic and must only be
// written while no request is in flight.
module vertical_scroll_blit_planner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  vsbp_pkg::t_in                 i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output vsbp_pkg::t_out                o_out_data,
    input  logic                          i_out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vsbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [vsbp_pkg::DATA_W-1:0]   pwdata,
    output logic [vsbp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    vsbp_pkg::t_cfg cfg;
    vsbp_pkg::t_in  r_in;
    logic           r_in_vld;
    vsbp_pkg::t_out plan;
    vsbp_pkg::t_out r_out;
    logic           r_out_vld;
    logic           out_free;
    logic           load_out;
    logic           in_free;

    vsbp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vsbp_plan u_plan (
        .i_cfg  (cfg),
        .i_req  (r_in),
        .o_plan (plan)
    );

    assign out_free   = !r_out_vld || !i_out_stall;
    assign load_out   = r_in_vld && out_free;
    assign in_free    = !r_in_vld || load_out;
    assign o_in_stall = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (load_out) begin
            r_out <= plan;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ design/vsbp_regs.sv @@
// APB-style configuration registers: viewport width, viewport height, content height.
// Depends on vsbp_pkg.
module vsbp_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vsbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [vsbp_pkg::DATA_W-1:0]   pwdata,
    output logic [vsbp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output vsbp_pkg::t_cfg                o_cfg
);

    vsbp_pkg::t_cfg r_cfg;
    vsbp_pkg::t_cfg n_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[3:2])
                vsbp_pkg::REG_VIEW_COLS: n_cfg.view_cols = pwdata[13:0];
                vsbp_pkg::REG_VIEW_ROWS: n_cfg.view_rows = pwdata[13:0];
                vsbp_pkg::REG_DOC_ROWS:  n_cfg.doc_rows  = pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_cols <= vsbp_pkg::RST_VIEW_COLS;
            r_cfg.view_rows <= vsbp_pkg::RST_VIEW_ROWS;
            r_cfg.doc_rows  <= vsbp_pkg::RST_DOC_ROWS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            vsbp_pkg::REG_VIEW_COLS: prdata = {18'd0, r_cfg.view_cols};
            vsbp_pkg::REG_VIEW_ROWS: prdata = {18'd0, r_cfg.view_rows};
            vsbp_pkg::REG_DOC_ROWS:  prdata = {17'd0, r_cfg.doc_rows};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/vsbp_plan.sv @@
// Combinational planning logic: clamp offsets, pick the mode, size the blit and strip.
// Depends on vsbp_pkg.
module vsbp_plan (
    input  vsbp_pkg::t_cfg i_cfg,
    input  vsbp_pkg::t_in  i_req,
    output vsbp_pkg::t_out o_plan
);

    logic [13:0] vw;
    logic [13:0] vh;
    logic [14:0] ch;
    logic        dim_zero;
    logic [14:0] limit;
    logic [14:0] cprev;
    logic [14:0] ccur;
    logic [14:0] ad;
    logic        span;
    logic [12:0] moved;
    logic [13:0] epix_rows;
    logic [27:0] mpix;
    logic [27:0] epix;

    function automatic logic [14:0] clamp_off(input logic [15:0] v, input logic [14:0] lim);
        logic [14:0] r;
        if (v[15]) begin
            r = '0;
        end else if (v[14:0] > lim) begin
            r = lim;
        end else begin
            r = v[14:0];
        end
        return r;
    endfunction

    assign vw = (i_cfg.view_cols > vsbp_pkg::MAX_VIEWPORT_DIM) ?
                vsbp_pkg::MAX_VIEWPORT_DIM : i_cfg.view_cols;
    assign vh = (i_cfg.view_rows > vsbp_pkg::MAX_VIEWPORT_DIM) ?
                vsbp_pkg::MAX_VIEWPORT_DIM : i_cfg.view_rows;
    assign ch = i_cfg.doc_rows;

    assign dim_zero = (vw == '0) || (vh == '0) || (ch == '0);
    assign limit    = (ch > {1'b0, vh}) ? (ch - {1'b0, vh}) : '0;

    assign cprev = clamp_off(i_req.previous_offset, limit);
    assign ccur  = clamp_off(i_req.requested_offset, limit);
    assign ad    = (ccur >= cprev) ? (ccur - cprev) : (cprev - ccur);
    assign span  = ad >= {1'b0, vh};

    // ad < vh <= 8192 whenever a fast blit is chosen, so 13 bits suffice there
    assign moved     = span ? '0 : 13'(vh - ad[13:0]);
    assign epix_rows = span ? vh : ad[13:0];
    assign mpix      = vw * {1'b0, moved};
    assign epix      = vw * epix_rows;

    always_comb begin
        o_plan = '0;
        o_plan.blit_mode = vsbp_pkg::MODE_NONE;
        if (dim_zero) begin
            o_plan.blit_mode = vsbp_pkg::MODE_FULL;
        end else begin
            o_plan.clamped_previous = cprev;
            o_plan.clamped_current  = ccur;
            o_plan.scroll_delta     = $signed({1'b0, ccur}) - $signed({1'b0, cprev});
            if (ad != '0) begin
                o_plan.strip_rows          = epix_rows;
                o_plan.exposed_pixel_count = epix[26:0];
                if (span) begin
                    o_plan.blit_mode = vsbp_pkg::MODE_FULL;
                end else begin
                    o_plan.blit_mode         = vsbp_pkg::MODE_FAST;
                    o_plan.moved_rows        = moved;
                    o_plan.moved_pixel_count = mpix[25:0];
                    if (ccur > cprev) begin
                        o_plan.source_row = ad[12:0];
                        o_plan.strip_row  = moved;
                    end else begin
                        o_plan.dest_row   = ad[12:0];
                    end
                end
            end
        end
    end

endmodule

@@ design/vsbp_checker.sv @@
// Port-level checks for the vertical scroll blit planner, bound to the top level.
// Depends on vsbp_pkg and vertical_scroll_blit_planner.
module vsbp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input vsbp_pkg::t_out o_out_data,
    input logic           i_out_stall
);

    // nothing comes out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    // input backs up only when the result register is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with result side free");

    // fast blit moves rows one way: either source or destination starts at the top
    a_fast_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.blit_mode == vsbp_pkg::MODE_FAST |->
            o_out_data.moved_rows != '0 && o_out_data.strip_rows != '0 &&
            (o_out_data.source_row == '0 || o_out_data.dest_row == '0))
        else $error("malformed fast blit plan");

endmodule

bind vertical_scroll_blit_planner vsbp_checker u_vsbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

@@ dv/vsbp_plan_sb_pkg.sv @@
// Scoreboard for the vertical scroll blit planner: predicts each scroll plan and checks results.
// Depends on vsbp_pkg for the beat types, mode codes, register codes and reset values.
package vsbp_plan_sb_pkg;

    import vsbp_pkg::*;

    class scroll_plan_scoreboard;

        logic [13:0] vp_width;
        logic [13:0] vp_height;
        logic [14:0] content_rows;
        t_out        plans_due[$];
        int          errors;
        int          requests;
        int          mode_hits[4];

        function new();
            vp_width     = RST_VIEW_COLS;
            vp_height    = RST_VIEW_ROWS;
            content_rows = RST_DOC_ROWS;
            errors       = 0;
            requests     = 0;
            foreach (mode_hits[i]) mode_hits[i] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] word);
            case (idx)
                REG_VIEW_COLS: vp_width     = word[13:0];
                REG_VIEW_ROWS: vp_height    = word[13:0];
                REG_DOC_ROWS:  content_rows = word[14:0];
                default: ;
            endcase
        endfunction

        // oversized viewport dimensions saturate
        function int sat_dim(logic [13:0] v);
            return (v > MAX_VIEWPORT_DIM) ? int'(MAX_VIEWPORT_DIM) : int'(v);
        endfunction

        function int viewport_rows();
            return sat_dim(vp_height);
        endfunction

        function int scroll_limit();
            int lim;
            lim = int'(content_rows) - sat_dim(vp_height);
            return (lim < 0) ? 0 : lim;
        endfunction

        function int clamp_offset(int v, int lim);
            if (v < 0) return 0;
            if (v > lim) return lim;
            return v;
        endfunction

        function t_out plan_scroll(t_in req);
            t_out plan;
            int   vw, vh, lim, cprev, ccur, delta, ad, moved, mpix, epix;
            plan = '0;
            plan.blit_mode = MODE_NONE;
            vw = sat_dim(vp_width);
            vh = sat_dim(vp_height);
            if (vw == 0 || vh == 0 || content_rows == 0) begin
                plan.blit_mode = MODE_FULL;
                return plan;
            end
            lim   = scroll_limit();
            cprev = clamp_offset(int'($signed(req.previous_offset)), lim);
            ccur  = clamp_offset(int'($signed(req.requested_offset)), lim);
            delta = ccur - cprev;
            plan.clamped_previous = cprev[14:0];
            plan.clamped_current  = ccur[14:0];
            plan.scroll_delta     = delta[15:0];
            if (delta == 0) return plan;
            ad = (delta < 0) ? -delta : delta;
            if (ad >= vh) begin
                epix = vw * vh;
                plan.blit_mode           = MODE_FULL;
                plan.strip_rows          = vh[13:0];
                plan.exposed_pixel_count = epix[26:0];
            end else begin
                moved = vh - ad;
                mpix  = vw * moved;
                epix  = vw * ad;
                plan.blit_mode  = MODE_FAST;
                plan.moved_rows = moved[12:0];
                plan.strip_rows = ad[13:0];
                // scrolling down pulls rows up and exposes the bottom strip
                if (delta > 0) begin
                    plan.source_row = ad[12:0];
                    plan.strip_row  = moved[12:0];
                end else begin
                    plan.dest_row = ad[12:0];
                end
                plan.moved_pixel_count   = mpix[25:0];
                plan.exposed_pixel_count = epix[26:0];
            end
            return plan;
        endfunction

        function void note_request(t_in req);
            plans_due.push_back(plan_scroll(req));
            requests++;
        endfunction

        function int pending();
            return plans_due.size();
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_plan(t_out got);
            t_out exp_p;
            if (plans_due.size() == 0) begin
                $display("%0t: plan with no request outstanding: expected none, actual %p",
                         $time, got);
                errors++;
                return;
            end
            exp_p = plans_due.pop_front();
            mode_hits[exp_p.blit_mode]++;
            check_field("blit_mode", 32'(exp_p.blit_mode), 32'(got.blit_mode));
            check_field("clamped_previous", 32'(exp_p.clamped_previous),
                        32'(got.clamped_previous));
            check_field("clamped_current", 32'(exp_p.clamped_current),
                        32'(got.clamped_current));
            check_field("scroll_delta", 32'(exp_p.scroll_delta), 32'(got.scroll_delta));
            check_field("source_row", 32'(exp_p.source_row), 32'(got.source_row));
            check_field("dest_row", 32'(exp_p.dest_row), 32'(got.dest_row));
            check_field("moved_rows", 32'(exp_p.moved_rows), 32'(got.moved_rows));
            check_field("strip_row", 32'(exp_p.strip_row), 32'(got.strip_row));
            check_field("strip_rows", 32'(exp_p.strip_rows), 32'(got.strip_rows));
            check_field("moved_pixel_count", 32'(exp_p.moved_pixel_count),
                        32'(got.moved_pixel_count));
            check_field("exposed_pixel_count", 32'(exp_p.exposed_pixel_count),
                        32'(got.exposed_pixel_count));
        endfunction

    endclass

endpackage

@@ dv/tb_vertical_scroll_blit_planner.sv @@
// Testbench top for the vertical scroll blit planner: drives requests and APB writes, checks plans.
// Depends on vsbp_pkg, vsbp_plan_sb_pkg and the vertical_scroll_blit_planner RTL.
module tb_vertical_scroll_blit_planner;

    timeunit 1ns;
    timeprecision 1ps;

    import vsbp_pkg::*;
    import vsbp_plan_sb_pkg::*;

    typedef struct {
        int vw;
        int vh;
        int ch;
        int items;
        bit idle;
        bit hold;
    } t_setting;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int HOLD_CYCLES         = 150;
    localparam int CYCLE_LIMIT         = 400000;
    localparam int DIRECTED_N          = 20;
    localparam int SETTINGS_N          = 15;

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 in_valid = 1'b0;
    t_in                  in_data = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out                 out_data;
    logic                 out_stall = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_W-1:0]    paddr   = '0;
    logic [DATA_W-1:0]    pwdata  = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    scroll_plan_scoreboard plans;

    bit idle_on = 1'b0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int stall_left = 0;
    int free_left = 0;
    int cycle_count = 0;
    int last_requested = 0;
    int settings_written = 0;

    // directed pairs, exercised at 640x480 over 2000 content rows (limit 1520)
    int dir_prev [DIRECTED_N] = '{0, -32768, 32767, -1, 0, 1, 0, 479, 0, 480,
                                  1520, 1041, 100, 200, 300, 21845, -21846, 1519, 1600, 240};
    int dir_req  [DIRECTED_N] = '{0, 32767, -32768, -32768, 1, 0, 479, 0, 480, 0,
                                  1521, 1520, 100, 300, 200, -21846, 21845, 1520, -3, 0};

    t_setting settings [SETTINGS_N] = '{
        '{640,   480,   2000,  70, 1'b1, 1'b0},
        '{16,    16,    200,   50, 1'b1, 1'b0},
        '{1,     1,     5,     25, 1'b1, 1'b0},
        '{8192,  8192,  32767, 40, 1'b1, 1'b0},
        '{16383, 16383, 32767, 30, 1'b1, 1'b0},
        '{8193,  9000,  20000, 25, 1'b1, 1'b0},
        '{0,     480,   2000,  15, 1'b1, 1'b0},
        '{640,   0,     2000,  15, 1'b1, 1'b0},
        '{640,   480,   0,     15, 1'b1, 1'b0},
        '{100,   300,   50,    20, 1'b1, 1'b0},
        '{320,   64,    32767, 70, 1'b1, 1'b1},
        '{5,     7,     40,    40, 1'b1, 1'b0},
        '{8192,  1,     32767, 30, 1'b1, 1'b0},
        '{1,     8191,  16000, 30, 1'b1, 1'b0},
        '{640,   480,   2000,  60, 1'b0, 1'b0}
    };

    vertical_scroll_blit_planner dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) plans.check_plan(out_data);
    end

    // result side: random stall bursts, plus long hold-offs on request
    always @(negedge clk) begin
        if (holds_asked > holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!idle_on) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(0, 15);
            out_stall <= 1'b1;
        end else begin
            free_left = $urandom_range(0, 24);
            out_stall <= 1'b0;
        end
    end

    function automatic t_in pack_request(int prev, int req);
        t_in r;
        r.previous_offset  = prev[15:0];
        r.requested_offset = req[15:0];
        return r;
    endfunction

    function automatic int pick_offset(int lim);
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return -int'($urandom_range(1, 40));
            2: return lim + int'($urandom_range(1, 40));
            3: return lim;
            4: return 0;
            default: return int'($urandom_range(0, lim));
        endcase
    endfunction

    // continuing scroll sequences: previous is the last request about half of the time
    function automatic t_in next_request();
        t_in r;
        int  lim, span, prev, req, step;
        lim  = plans.scroll_limit();
        span = plans.viewport_rows() + 2;
        prev = ($urandom_range(0, 1) == 1) ? last_requested : pick_offset(lim);
        case ($urandom_range(0, 9))
            0, 1: req = prev;
            2, 3, 4, 5, 6: begin
                step = int'($urandom_range(1, span));
                req  = ($urandom_range(0, 1) == 1) ? prev + step : prev - step;
            end
            default: req = pick_offset(lim);
        endcase
        r = pack_request(prev, req);
        last_requested = int'($signed(r.requested_offset));
        return r;
    endfunction

    task automatic offer_request(input t_in req);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        plans.note_request(req);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (plans.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        logic [31:0] word;
        word       = $urandom;
        word[14:0] = value[14:0];
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        plans.write_reg(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_view(input int vw, input int vh, input int ch);
        write_reg(REG_VIEW_COLS, vw);
        write_reg(REG_VIEW_ROWS, vh);
        write_reg(REG_DOC_ROWS, ch);
        // unmapped register: must leave the view registers alone
        write_reg(REG_UNUSED, int'($urandom));
        settings_written++;
    endtask

    initial begin
        plans = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_on = 1'b1;

        // reset values first
        repeat (10) offer_request(next_request());
        drain();

        program_view(640, 480, 2000);
        for (int i = 0; i < DIRECTED_N; i++) offer_request(pack_request(dir_prev[i], dir_req[i]));
        drain();

        foreach (settings[s]) begin
            program_view(settings[s].vw, settings[s].vh, settings[s].ch);
            idle_on = settings[s].idle;
            if (settings[s].hold) holds_asked++;
            repeat (settings[s].items) offer_request(next_request());
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Ran %0d scroll requests across %0d view setups plus reset defaults",
                 plans.requests, settings_written);
        $display("Plans seen: %0d no-move, %0d fast blit, %0d full repaint",
                 plans.mode_hits[MODE_NONE], plans.mode_hits[MODE_FAST],
                 plans.mode_hits[MODE_FULL]);
        if (plans.errors == 0 && plans.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/vsbp_pkg.sv
design/vsbp_regs.sv
design/vsbp_plan.sv
design/vertical_scroll_blit_planner.sv
design/vsbp_checker.sv
dv/vsbp_plan_sb_pkg.sv
dv/tb_vertical_scroll_blit_planner.sv
